FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// An implication that must hold at every clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sfh_pkg.sv
`default_nettype none

package sfh_pkg;

    localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam int          STIR_SHIFT = 13;

    localparam int DEF_STIR_ROUNDS = 4096;
    localparam int DEF_SALT_LENGTH = 14;

    // The salt table has 64 positions; those past the fixed salt text read as zero.
    localparam int SALT_TAB_AW = 6;

    function automatic logic [7:0] salt_byte(input logic [SALT_TAB_AW-1:0] addr);
        logic [7:0] b;
        unique case (addr)
            6'd0:    b = 8'h4C;
            6'd1:    b = 8'h69;
            6'd2:    b = 8'h67;
            6'd3:    b = 8'h68;
            6'd4:    b = 8'h74;
            6'd5:    b = 8'h6E;
            6'd6:    b = 8'h69;
            6'd7:    b = 8'h6E;
            6'd8:    b = 8'h67;
            6'd9:    b = 8'h4F;
            6'd10:   b = 8'h53;
            6'd11:   b = 8'h2F;
            6'd12:   b = 8'h76;
            6'd13:   b = 8'h32;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/salted_fnv1a_stretched_hash_core.sv
// A password byte that is not the first of a message is absorbed in its accept cycle.
// A message's first request first mixes in the SALT_LENGTH salt bytes, then its byte if it carries one.
// A last request then runs the STIR_ROUNDS stirring rounds and loads the digest register,
// waiting while an earlier digest is still held off; stall stays high through all of these.
// No new request is taken until the sequencer is back in idle.
// Async active-low reset idles the sequencer, clears output valid and loads the FNV basis.
`default_nettype none

`include "assert_macros.svh"

module salted_fnv1a_stretched_hash_core #(
    parameter int STIR_ROUNDS = sfh_pkg::DEF_STIR_ROUNDS,
    parameter int SALT_LENGTH = sfh_pkg::DEF_SALT_LENGTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        last,
    output logic             digest_valid,
    input  wire logic        digest_stall,
    output logic [31:0]      digest
);

    import sfh_pkg::*;

    localparam int RW = (STIR_ROUNDS > 1) ? $clog2(STIR_ROUNDS) : 1;
    localparam int SW = (SALT_LENGTH > 1) ? $clog2(SALT_LENGTH) : 1;
    localparam logic [RW-1:0] ROUND_LAST = RW'(STIR_ROUNDS - 1);
    localparam logic [SW-1:0] SALT_LAST  = SW'(SALT_LENGTH - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SALT = 3'd1;
    localparam logic [2:0] ST_BYTE = 3'd2;
    localparam logic [2:0] ST_STIR = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [31:0]   hash_reg, hash_next;
    logic          at_start_reg, at_start_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   digest_reg, digest_next;
    logic [7:0]    byte_reg, byte_next;
    logic          has_reg, has_next;
    logic          last_reg, last_next;
    logic [RW-1:0] round_reg, round_next;
    logic [SW-1:0] salt_cnt_reg, salt_cnt_next;

    logic [SALT_TAB_AW-1:0] salt_addr;
    logic [31:0]            mul_in;
    logic [31:0]            mul_out;
    logic                   accept;

    assign stall        = (state_reg != ST_IDLE);
    assign accept       = valid && !stall;
    assign digest_valid = out_valid_reg;
    assign digest       = digest_reg;
    assign salt_addr    = SALT_TAB_AW'(salt_cnt_reg);

    // The one shared multiplier; each absorbing or stirring phase feeds it its own premixed operand.
    assign mul_out = mul_in * FNV_PRIME;

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        at_start_next  = at_start_reg;
        out_valid_next = out_valid_reg && digest_stall;
        digest_next    = digest_reg;
        byte_next      = byte_reg;
        has_next       = has_reg;
        last_next      = last_reg;
        round_next     = round_reg;
        salt_cnt_next  = salt_cnt_reg;
        mul_in         = hash_reg ^ {24'd0, byte_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                mul_in = hash_reg ^ {24'd0, data_byte};
                if (accept)
                begin
                    byte_next = data_byte;
                    has_next  = has_byte;
                    last_next = last;
                    if (at_start_reg)
                    begin
                        state_next    = ST_SALT;
                        salt_cnt_next = '0;
                    end
                    else
                    begin
                        if (has_byte)
                        begin
                            hash_next = mul_out;
                        end
                        if (last)
                        begin
                            state_next = ST_STIR;
                            round_next = '0;
                        end
                    end
                end
            end
            ST_SALT:
            begin
                mul_in        = hash_reg ^ {24'd0, salt_byte(salt_addr)};
                hash_next     = mul_out;
                salt_cnt_next = salt_cnt_reg + 1'b1;
                if (salt_cnt_reg == SALT_LAST)
                begin
                    at_start_next = 1'b0;
                    round_next    = '0;
                    if (has_reg)
                    begin
                        state_next = ST_BYTE;
                    end
                    else if (last_reg)
                    begin
                        state_next = ST_STIR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BYTE:
            begin
                mul_in     = hash_reg ^ {24'd0, byte_reg};
                hash_next  = mul_out;
                round_next = '0;
                state_next = last_reg ? ST_STIR : ST_IDLE;
            end
            ST_STIR:
            begin
                mul_in     = hash_reg ^ (hash_reg >> STIR_SHIFT);
                hash_next  = mul_out ^ 32'(round_reg);
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Wait here until the output register is free.
                if (!out_valid_reg || !digest_stall)
                begin
                    digest_next    = (hash_reg == 32'd0) ? 32'd1 : hash_reg;
                    out_valid_next = 1'b1;
                    hash_next      = FNV_BASIS;
                    at_start_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= FNV_BASIS;
            at_start_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            at_start_reg  <= at_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digest_reg   <= digest_next;
        byte_reg     <= byte_next;
        has_reg      <= has_next;
        last_reg     <= last_next;
        round_reg    <= round_next;
        salt_cnt_reg <= salt_cnt_next;
    end

    `ASSERT_IMPLIES(a_digest_nonzero, out_valid_reg, digest_reg != 32'd0,
        "digest presented as zero")
    `ASSERT_IMPLIES(a_idle_basis, (state_reg == ST_IDLE) && at_start_reg,
        hash_reg == FNV_BASIS, "hash not at offset basis at message start")
    `ASSERT_IMPLIES(a_stir_from_zero, (state_reg == ST_STIR) && ($past(state_reg) != ST_STIR),
        round_reg == '0, "stirring did not start at round zero")
    `ASSERT_ALWAYS(a_result_from_fin, !$rose(out_valid_reg) || ($past(state_reg) == ST_FIN),
        "result raised outside the final step")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STIR_ROUNDS   = 4096;
    localparam int          SALT_LENGTH   = 14;
    localparam int          SALT_TEXT_LEN = 14;
    localparam logic [31:0] HASH_BASIS    = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME    = 32'd16777619;
    localparam int          MIX_SHIFT     = 13;
    localparam int          IDLE_LIMIT    = 40000;
    localparam int          HOLD_CYCLES   = 12000;

    localparam logic [7:0] SALT_TEXT [SALT_TEXT_LEN] = '{
        8'h4C, 8'h69, 8'h67, 8'h68, 8'h74, 8'h6E, 8'h69,
        8'h6E, 8'h67, 8'h4F, 8'h53, 8'h2F, 8'h76, 8'h32
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        valid = 1'b0;
    logic        stall;
    logic [7:0]  data_byte = 8'h00;
    logic        has_byte = 1'b0;
    logic        last = 1'b0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [31:0] digest;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_count = 0;
    int          idle_cycles = 0;
    int          fail_count = 0;

    logic [31:0] pw_hash = HASH_BASIS;
    bit          pw_fresh = 1'b1;
    logic [31:0] pending_digests[$];

    always #2 clk = ~clk;

    salted_fnv1a_stretched_hash_core #(
        .STIR_ROUNDS(STIR_ROUNDS),
        .SALT_LENGTH(SALT_LENGTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .valid(valid),
        .stall(stall),
        .data_byte(data_byte),
        .has_byte(has_byte),
        .last(last),
        .digest_valid(digest_valid),
        .digest_stall(digest_stall),
        .digest(digest)
    );

    function automatic logic [31:0] fnv_absorb(input logic [31:0] h, input logic [7:0] b);
        return (h ^ {24'd0, b}) * HASH_PRIME;
    endfunction

    function automatic logic [31:0] stretch_digest(input logic [31:0] seed);
        logic [31:0] h;
        h = seed;
        for (int r = 0; r < STIR_ROUNDS; r++)
        begin
            h = h ^ (h >> MIX_SHIFT);
            h = h * HASH_PRIME;
            h = h ^ r[31:0];
        end
        return (h == 32'd0) ? 32'd1 : h;
    endfunction

    // Track the password hash for every accepted request.
    task automatic absorb_request(input logic [7:0] b, input logic has, input logic is_last);
        if (pw_fresh)
        begin
            for (int i = 0; i < SALT_LENGTH; i++)
                pw_hash = fnv_absorb(pw_hash, (i < SALT_TEXT_LEN) ? SALT_TEXT[i] : 8'h00);
            pw_fresh = 1'b0;
        end
        if (has)
            pw_hash = fnv_absorb(pw_hash, b);
        if (is_last)
        begin
            pending_digests.push_back(stretch_digest(pw_hash));
            pw_hash = HASH_BASIS;
            pw_fresh = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && valid && !stall)
            absorb_request(data_byte, has_byte, last);
    end

    always @(posedge clk)
    begin
        if (rst_n && digest_valid && !digest_stall)
        begin
            if (pending_digests.size() == 0)
            begin
                $error("digest with no request pending: actual %08h", digest);
                fail_count++;
            end
            else
            begin
                logic [31:0] want;
                want = pending_digests.pop_front();
                if (digest !== want)
                begin
                    $error("digest mismatch: expected %08h, actual %08h", want, digest);
                    fail_count++;
                end
            end
        end
    end

    // Output stall: a long hold-off when requested, otherwise random.
    always @(posedge clk)
    begin
        if (hold_count != 0)
        begin
            digest_stall <= 1'b1;
            hold_count <= hold_count - 1;
        end
        else
            digest_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (valid && !stall) || (digest_valid && !digest_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(input logic [7:0] b, input logic has, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            valid <= 1'b0;
            data_byte <= 8'($urandom);
            @(posedge clk);
        end
        valid <= 1'b1;
        data_byte <= b;
        has_byte <= has;
        last <= is_last;
        do
            @(posedge clk);
        while (stall);
    endtask

    task automatic release_input();
        valid <= 1'b0;
        @(posedge clk);
    endtask

    // A password of len bytes, now and then with byteless filler requests,
    // closed by a last request that may or may not carry a byte.
    task automatic send_password(input int len, inout int sent);
        bit tail_has;
        int body;
        tail_has = $urandom_range(1);
        body = (tail_has && len > 0) ? len - 1 : len;
        for (int i = 0; i < body; i++)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_request(8'($urandom), 1'b0, 1'b0);
                sent++;
            end
            send_request(8'($urandom), 1'b1, 1'b0);
            sent++;
        end
        send_request(8'($urandom), tail_has && len > 0, 1'b1);
        sent++;
    endtask

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 0;
        if (roll < 75)
            return $urandom_range(6, 1);
        if (roll < 95)
            return $urandom_range(16, 7);
        return $urandom_range(48, 24);
    endfunction

    task automatic test_special_cases();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Empty password.
        send_request(8'hA5, 1'b0, 1'b1);
        // Single bytes at both extremes.
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hFF, 1'b1, 1'b1);
        // Zero bytes count toward the password.
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h00, 1'b1, 1'b1);
        // A byteless request opens the message, another sits in the middle.
        send_request(8'h5A, 1'b0, 1'b0);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'h7F, 1'b1, 1'b0);
        send_request(8'h01, 1'b1, 1'b1);
        // Password ended by a last request that carries no byte.
        send_request(8'h55, 1'b1, 1'b0);
        send_request(8'hAA, 1'b1, 1'b0);
        send_request(8'h33, 1'b0, 1'b1);
        release_input();
        wait (pending_digests.size() == 0);
    endtask

    task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
        int sent;
        sent = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < n_items)
            send_password(pick_length(), sent);
        release_input();
        wait (pending_digests.size() == 0);
    endtask

    task automatic test_output_backpressure();
        int sent;
        sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_count <= HOLD_CYCLES;
        @(posedge clk);
        for (int m = 0; m < 4; m++)
            send_password($urandom_range(5, 1), sent);
        release_input();
        wait (pending_digests.size() == 0);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_random_traffic(310, 30, 50);
        test_random_traffic(310, 50, 30);
        test_output_backpressure();
        test_random_traffic(310, 0, 0);

        repeat (SALT_LENGTH + 16) @(posedge clk);
        if (pending_digests.size() != 0)
        begin
            $error("%0d digests never arrived", pending_digests.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/sfh_pkg.sv
hw/rtl/salted_fnv1a_stretched_hash_core.sv
tb/sv/testbench.sv
